// File: rtl/ecind_pkg.sv
// Shared types and constants for the encoder carousel indexer.
`default_nettype none
package ecind_pkg;

  localparam logic [1:0] CMD_EDGE = 2'd0;
  localparam logic [1:0] CMD_MOVE = 2'd1;
  localparam logic [1:0] CMD_SET  = 2'd2;

  localparam logic [1:0] MOTOR_OFF = 2'd0;
  localparam logic [1:0] MOTOR_CW  = 2'd1;
  localparam logic [1:0] MOTOR_CCW = 2'd2;

  localparam logic REG_EDGES_PER_TURN = 1'b0;
  localparam logic REG_TURNS_PER_SLOT = 1'b1;

  localparam logic [6:0] EDGES_PER_TURN_RST = 7'd56;
  localparam logic [3:0] TURNS_PER_SLOT_RST = 4'd4;

  typedef struct packed {
    logic [1:0] cmd;
    logic       channel_b;
    logic [3:0] target_slot;
  } item_t;

  typedef struct packed {
    logic [3:0] slot_now;
    logic [1:0] motor_drive;
    logic       at_target;
  } result_t;

  typedef struct packed {
    logic [6:0] edges_per_turn;
    logic [3:0] turns_per_slot;
  } cfg_t;

endpackage
`default_nettype wire

// File: rtl/encoder_carousel_indexer.sv
// Top level of the encoder carousel indexer: handshake stages around the core.
// Usage:
// Items enter on the input channel (in_valid, in_stall, cmd, channel_b,
// target_slot): an encoder edge, a move to a target slot or a load of the
// current slot. Every item gives exactly one result on the output channel
// (out_valid, out_stall, slot_now, motor_drive, at_target).
// A transfer happens at a rising edge where valid is high and stall is low.
// The item is held in an input register; when the output stage can advance,
// the core updates the counters, slot and motor state and the result is
// captured in the output register. One item is taken every cycle while the
// receiver does not stall; the core's state update sets that rate.
// When the receiver stalls, the output register holds its result and the input
// register keeps one more item; in_stall rises only when both are full.
// The configuration port (cfg_we, cfg_index, cfg_data) writes edges_per_turn
// (index 0) and turns_per_slot (index 1); the user writes it only while the
// block is idle, which the block itself does not enforce. Synchronous reset
// empties both stages, clears the counts, sets slot and target to 1, switches
// the motor off and restores the registers to 56 and 4.
`default_nettype none
module encoder_carousel_indexer
  import ecind_pkg::*;
#(
  parameter int NUM_SLOTS = 12
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [1:0] cmd,
  input  wire logic       channel_b,
  input  wire logic [3:0] target_slot,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [3:0]      slot_now,
  output logic [1:0]      motor_drive,
  output logic            at_target,
  input  wire logic       cfg_we,
  input  wire logic       cfg_index,
  input  wire logic [6:0] cfg_data
);

  cfg_t    cfg;
  item_t   item;
  result_t result;
  logic    item_valid;
  logic    advance;
  logic    step;

  assign advance  = !out_valid || !out_stall;
  assign step     = item_valid && advance;
  assign in_stall = item_valid && !advance;

  ecind_regs u_regs (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  ecind_core #(
    .NUM_SLOTS (NUM_SLOTS)
  ) u_core (
    .clk    (clk),
    .rst    (rst),
    .step   (step),
    .item   (item),
    .cfg    (cfg),
    .result (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (!in_stall) begin
        item_valid <= in_valid;
      end
      if (advance) begin
        out_valid <= item_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      item.cmd         <= cmd;
      item.channel_b   <= channel_b;
      item.target_slot <= target_slot;
    end
    if (step) begin
      slot_now    <= result.slot_now;
      motor_drive <= result.motor_drive;
      at_target   <= result.at_target;
    end
  end

endmodule
`default_nettype wire

// File: rtl/ecind_regs.sv
// Configuration registers of the encoder carousel indexer.
`default_nettype none
module ecind_regs
  import ecind_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       cfg_we,
  input  wire logic       cfg_index,
  input  wire logic [6:0] cfg_data,
  output cfg_t            cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.edges_per_turn <= EDGES_PER_TURN_RST;
      cfg.turns_per_slot <= TURNS_PER_SLOT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_EDGES_PER_TURN: cfg.edges_per_turn <= cfg_data;
        REG_TURNS_PER_SLOT: cfg.turns_per_slot <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

endmodule
`default_nettype wire

// File: rtl/ecind_core.sv
// Position and motor state of the carousel and its one-item update.
`default_nettype none
module ecind_core
  import ecind_pkg::*;
#(
  parameter int NUM_SLOTS = 12
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic step,
  input  wire item_t item,
  input  wire cfg_t  cfg,
  output result_t   result
);

  localparam logic [3:0] SLOT_MAX = 4'(NUM_SLOTS);
  localparam logic [3:0] HALF     = 4'(NUM_SLOTS / 2);

  logic signed [7:0] edge_count, edge_count_next;
  logic signed [4:0] turn_count, turn_count_next;
  logic [3:0]        slot_reg, slot_reg_next;
  logic [3:0]        target_reg, target_reg_next;
  logic [1:0]        motor_reg, motor_reg_next;

  logic signed [8:0] edge_sum, e_lim;
  logic signed [5:0] turn_up, turn_dn, t_lim;
  logic [3:0]        slot_inc, slot_dec, gap_dn, gap_up;
  logic              tgt_ok;
  logic [1:0]        motor_pick;

  always_comb begin
    e_lim    = $signed({2'b00, cfg.edges_per_turn});
    t_lim    = $signed({2'b00, cfg.turns_per_slot});
    edge_sum = $signed({edge_count[7], edge_count}) + (item.channel_b ? 9'sd1 : -9'sd1);
    turn_up  = $signed({turn_count[4], turn_count}) + 6'sd1;
    turn_dn  = $signed({turn_count[4], turn_count}) - 6'sd1;
    slot_inc = (slot_reg >= SLOT_MAX) ? 4'd1 : slot_reg + 4'd1;
    slot_dec = (slot_reg <= 4'd1) ? SLOT_MAX : slot_reg - 4'd1;
    tgt_ok   = (item.target_slot >= 4'd1) && (item.target_slot <= SLOT_MAX);
    gap_dn   = slot_reg - item.target_slot;
    gap_up   = item.target_slot - slot_reg;

    if (slot_reg == item.target_slot) begin
      motor_pick = MOTOR_OFF;
    end else if (slot_reg > item.target_slot) begin
      motor_pick = (gap_dn < HALF) ? MOTOR_CW : MOTOR_CCW;
    end else begin
      motor_pick = (gap_up < HALF) ? MOTOR_CCW : MOTOR_CW;
    end

    edge_count_next = edge_count;
    turn_count_next = turn_count;
    slot_reg_next   = slot_reg;
    target_reg_next = target_reg;
    motor_reg_next  = motor_reg;

    case (item.cmd)
      CMD_EDGE: begin
        if (edge_sum >= e_lim) begin
          edge_count_next = 8'sd0;
          if (turn_up >= t_lim) begin
            turn_count_next = 5'sd0;
            slot_reg_next   = slot_inc;
          end else begin
            turn_count_next = turn_up[4:0];
          end
        end else if (edge_sum <= -e_lim) begin
          edge_count_next = 8'sd0;
          if (turn_dn <= -t_lim) begin
            turn_count_next = 5'sd0;
            slot_reg_next   = slot_dec;
          end else begin
            turn_count_next = turn_dn[4:0];
          end
        end else begin
          edge_count_next = edge_sum[7:0];
        end
      end
      CMD_MOVE: begin
        if (tgt_ok) begin
          target_reg_next = item.target_slot;
          motor_reg_next  = motor_pick;
        end
      end
      CMD_SET: begin
        if (tgt_ok) begin
          slot_reg_next = item.target_slot;
        end
      end
      default: ;
    endcase

    if (motor_reg_next != MOTOR_OFF && slot_reg_next == target_reg_next) begin
      motor_reg_next = MOTOR_OFF;
    end

    result.slot_now    = slot_reg_next;
    result.motor_drive = motor_reg_next;
    result.at_target   = (motor_reg_next == MOTOR_OFF) && (slot_reg_next == target_reg_next);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      edge_count <= 8'sd0;
      turn_count <= 5'sd0;
      slot_reg   <= 4'd1;
      target_reg <= 4'd1;
      motor_reg  <= MOTOR_OFF;
    end else if (step) begin
      edge_count <= edge_count_next;
      turn_count <= turn_count_next;
      slot_reg   <= slot_reg_next;
      target_reg <= target_reg_next;
      motor_reg  <= motor_reg_next;
    end
  end

endmodule
`default_nettype wire

// File: sim/encoder_carousel_indexer_tb.sv
// Self-checking testbench for the encoder carousel indexer: queued stimulus, predictor, scoreboard.
`default_nettype none
module encoder_carousel_indexer_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import ecind_pkg::*;

  localparam int NUM_SLOTS = 12;
  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam int HOLD_CYCLES = 90;
  localparam int SEGMENTS = 8;
  localparam int SEG_ITEMS = 165;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [1:0] cmd = CMD_EDGE;
  logic channel_b = 1'b0;
  logic [3:0] target_slot = 4'd0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [3:0] slot_now;
  logic [1:0] motor_drive;
  logic at_target;
  logic cfg_we = 1'b0;
  logic cfg_index = REG_EDGES_PER_TURN;
  logic [6:0] cfg_data = 7'd0;

  encoder_carousel_indexer #(.NUM_SLOTS(NUM_SLOTS)) i_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .cmd(cmd), .channel_b(channel_b), .target_slot(target_slot),
    .out_valid(out_valid), .out_stall(out_stall),
    .slot_now(slot_now), .motor_drive(motor_drive), .at_target(at_target),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #4 clk = ~clk;

  // Predicted carousel state and register copies.
  logic [6:0] cfg_ept = EDGES_PER_TURN_RST;
  logic [3:0] cfg_tps = TURNS_PER_SLOT_RST;
  logic signed [7:0] pred_edges = '0;
  logic signed [4:0] pred_turns = '0;
  logic [3:0] pred_slot = 4'd1;
  logic [3:0] pred_target = 4'd1;
  logic [1:0] pred_motor = MOTOR_OFF;

  item_t pending_items[$];
  result_t expected_results[$];
  item_t offered;
  int mismatches = 0;
  int snd_idle_pct = 0;
  int rcv_idle_pct = 0;
  int hold_req = 0;
  int hold_ack = 0;
  int hold_left = 0;
  logic run_up = 1'b1;

  function automatic logic [1:0] pick_motor(logic [3:0] cur, logic [3:0] tgt);
    int half;
    half = NUM_SLOTS / 2;
    if (cur == tgt) return MOTOR_OFF;
    if (cur > tgt) return (int'(cur - tgt) < half) ? MOTOR_CW : MOTOR_CCW;
    return (int'(tgt - cur) < half) ? MOTOR_CCW : MOTOR_CW;
  endfunction

  function automatic result_t carousel_step(item_t it);
    int e;
    int t;
    logic in_range;
    result_t r;
    e = pred_edges;
    t = pred_turns;
    in_range = it.target_slot >= 1 && it.target_slot <= NUM_SLOTS;
    case (it.cmd)
      CMD_EDGE: begin
        e += it.channel_b ? 1 : -1;
        if (e >= int'(cfg_ept)) begin
          e = 0;
          t += 1;
          if (t >= int'(cfg_tps)) begin
            t = 0;
            pred_slot = (pred_slot >= NUM_SLOTS) ? 4'd1 : pred_slot + 4'd1;
          end
        end else if (e <= -int'(cfg_ept)) begin
          e = 0;
          t -= 1;
          if (t <= -int'(cfg_tps)) begin
            t = 0;
            pred_slot = (pred_slot <= 1) ? 4'(NUM_SLOTS) : pred_slot - 4'd1;
          end
        end
      end
      CMD_MOVE: begin
        if (in_range) begin
          pred_target = it.target_slot;
          pred_motor = pick_motor(pred_slot, it.target_slot);
        end
      end
      CMD_SET: begin
        if (in_range) pred_slot = it.target_slot;
      end
      default: ;
    endcase
    pred_edges = e[7:0];
    pred_turns = t[4:0];
    if (pred_motor != MOTOR_OFF && pred_slot == pred_target) pred_motor = MOTOR_OFF;
    r.slot_now = pred_slot;
    r.motor_drive = pred_motor;
    r.at_target = (pred_motor == MOTOR_OFF && pred_slot == pred_target);
    return r;
  endfunction

  // Mostly edges in direction runs so counts build up, with moves, loads and noise.
  function automatic item_t random_item();
    item_t it;
    int pick;
    pick = $urandom_range(99);
    it.cmd = CMD_EDGE;
    it.channel_b = 1'($urandom_range(1));
    it.target_slot = 4'($urandom_range(15));
    if (pick < 72) begin
      if ($urandom_range(9) == 0) run_up = ~run_up;
      it.channel_b = run_up;
    end else if (pick < 85) begin
      it.cmd = CMD_MOVE;
      it.target_slot = 4'($urandom_range(NUM_SLOTS, 1));
    end else if (pick < 91) begin
      it.cmd = CMD_SET;
      it.target_slot = 4'($urandom_range(NUM_SLOTS, 1));
    end else if (pick < 97) begin
      it.cmd = $urandom_range(1) ? CMD_MOVE : CMD_SET;
    end else begin
      it.cmd = CMD_UNUSED;
    end
    return it;
  endfunction

  task automatic push(logic [1:0] c, logic ch, logic [3:0] tgt);
    item_t it;
    it.cmd = c;
    it.channel_b = ch;
    it.target_slot = tgt;
    pending_items.push_back(it);
  endtask

  task automatic drain();
    while (pending_items.size() != 0 || in_valid || expected_results.size() != 0)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_cfg(logic [6:0] ept, logic [3:0] tps);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= REG_EDGES_PER_TURN;
    cfg_data <= ept;
    @(posedge clk);
    cfg_index <= REG_TURNS_PER_SLOT;
    cfg_data <= {3'b000, tps};
    @(posedge clk);
    cfg_we <= 1'b0;
    cfg_ept = ept;
    cfg_tps = tps;
  endtask

  always @(posedge clk) begin
    logic go;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) expected_results.push_back(carousel_step(offered));
      if (!in_valid || !in_stall) begin
        go = pending_items.size() != 0 && $urandom_range(99) >= snd_idle_pct;
        if (go) begin
          offered = pending_items.pop_front();
          cmd <= offered.cmd;
          channel_b <= offered.channel_b;
          target_slot <= offered.target_slot;
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else if (hold_req != hold_ack) begin
      hold_ack <= hold_req;
      hold_left <= HOLD_CYCLES;
      out_stall <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= $urandom_range(99) < rcv_idle_pct;
    end
  end

  always @(posedge clk) begin
    result_t want;
    result_t got;
    if (!rst && out_valid && !out_stall) begin
      got.slot_now = slot_now;
      got.motor_drive = motor_drive;
      got.at_target = at_target;
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected transfer slot %0d motor %0d at_target %0d", $time,
                 got.slot_now, got.motor_drive, got.at_target);
        mismatches++;
      end else begin
        want = expected_results.pop_front();
        if (got !== want) begin
          $display("%0t: expected slot %0d motor %0d at_target %0d, got %0d %0d %0d", $time,
                   want.slot_now, want.motor_drive, want.at_target,
                   got.slot_now, got.motor_drive, got.at_target);
          mismatches++;
        end
      end
    end
  end

  initial begin
    static int seg_ept[SEGMENTS] = '{1, 3, 127, 0, 20, 2, 7, 127};
    static int seg_tps[SEGMENTS] = '{1, 2, 15, 0, 5, 1, 3, 1};
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Default registers: ignored targets, the unused command and direction choice.
    push(CMD_UNUSED, 1'b1, 4'd15);
    push(CMD_MOVE, 1'b0, 4'd0);
    push(CMD_MOVE, 1'b1, 4'd15);
    push(CMD_MOVE, 1'b0, 4'd13);
    push(CMD_MOVE, 1'b0, 4'd1);
    push(CMD_SET, 1'b1, 4'd12);
    push(CMD_MOVE, 1'b0, 4'd1);
    push(CMD_MOVE, 1'b0, 4'd7);
    push(CMD_MOVE, 1'b1, 4'd6);
    push(CMD_EDGE, 1'b1, 4'd15);
    push(CMD_EDGE, 1'b0, 4'd0);
    push(CMD_SET, 1'b0, 4'd6);
    push(CMD_SET, 1'b1, 4'd0);
    push(CMD_SET, 1'b0, 4'd13);
    push(CMD_MOVE, 1'b0, 4'd12);
    push(CMD_MOVE, 1'b0, 4'd11);
    drain();

    // One edge per slot step: wrap both ways, then run to a target and stop.
    write_cfg(7'd1, 4'd1);
    push(CMD_SET, 1'b0, 4'd12);
    push(CMD_EDGE, 1'b1, 4'd0);
    push(CMD_EDGE, 1'b0, 4'd0);
    push(CMD_MOVE, 1'b0, 4'd10);
    push(CMD_EDGE, 1'b0, 4'd5);
    push(CMD_EDGE, 1'b0, 4'd10);
    push(CMD_EDGE, 1'b1, 4'd3);
    drain();

    for (int s = 0; s < SEGMENTS; s++) begin
      write_cfg(7'(seg_ept[s]), 4'(seg_tps[s]));
      snd_idle_pct = (s < 3) ? 28 : (s < 6) ? 47 : 0;
      rcv_idle_pct = (s < 3) ? 47 : (s < 6) ? 28 : 0;
      for (int n = 0; n < SEG_ITEMS; n++) pending_items.push_back(random_item());
      if (s == 1) begin
        repeat (20) @(posedge clk);
        hold_req++;
      end
      drain();
    end

    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
`default_nettype wire

// File: files.f
rtl/ecind_pkg.sv
rtl/ecind_regs.sv
rtl/ecind_core.sv
rtl/encoder_carousel_indexer.sv
sim/encoder_carousel_indexer_tb.sv
